/* rtl/gsp_pkg.sv */
// shared types, character codes and the saturating decimal accumulate for the geometry parser
package gsp_pkg;

   // width of the decimal accumulators, results saturate at 2^VALUE_BITS - 1
   localparam int VALUE_BITS = 16;
   localparam int OUT_BITS   = 17;
   localparam int CH_BITS    = 8;

   localparam logic [VALUE_BITS-1:0] VALUE_LIMIT = '1;

   localparam logic [CH_BITS-1:0] CH_X     = 8'h78;
   localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2d;
   localparam logic [CH_BITS-1:0] CH_EQUAL = 8'h3d;
   localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;

   typedef enum logic [6:0] {
      PH_START       = 7'b000_0001,
      PH_SIZE_W      = 7'b000_0010,
      PH_SIZE_H      = 7'b000_0100,
      PH_POS_X_FIRST = 7'b000_1000,
      PH_POS_X       = 7'b001_0000,
      PH_POS_Y_FIRST = 7'b010_0000,
      PH_POS_Y       = 7'b100_0000
   } phase_type;

   typedef struct packed {
      phase_type             phase;
      logic                  failed;
      logic [VALUE_BITS-1:0] width_acc;
      logic [VALUE_BITS-1:0] height_acc;
      logic [VALUE_BITS-1:0] x_acc;
      logic [VALUE_BITS-1:0] y_acc;
      logic                  x_negative;
      logic                  y_negative;
      logic                  size_seen;
      logic                  position_seen;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:         PH_START,
      failed:        1'b0,
      width_acc:     '0,
      height_acc:    '0,
      x_acc:         '0,
      y_acc:         '0,
      x_negative:    1'b0,
      y_negative:    1'b0,
      size_seen:     1'b0,
      position_seen: 1'b0
   };

   function automatic logic is_digit(input logic [CH_BITS-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_sign(input logic [CH_BITS-1:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   // acc * 10 + digit as two shifts and adds, clipped at the limit
   function automatic logic [VALUE_BITS-1:0] acc_digit(input logic [VALUE_BITS-1:0] acc,
                                                       input logic [CH_BITS-1:0]    c);
      logic [CH_BITS-1:0]    d;
      logic [VALUE_BITS+4:0] wide;
      logic [VALUE_BITS+4:0] sum;
      d    = c - CH_ZERO;
      wide = {5'b0, acc};
      sum  = (wide << 3) + (wide << 1) + {{(VALUE_BITS + 1){1'b0}}, d[3:0]};
      if (sum > {5'b0, VALUE_LIMIT}) begin
         return VALUE_LIMIT;
      end
      return sum[VALUE_BITS-1:0];
   endfunction

endpackage

/* rtl/gsp_req_if.sv */
// character item channel into the geometry parser
interface gsp_req_if import gsp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CH_BITS-1:0] ch;
   logic               end_of_string;

   modport source (output valid, output ch, output end_of_string, input ready);
   modport sink   (input valid, input ch, input end_of_string, output ready);
endinterface

/* rtl/gsp_rsp_if.sv */
// result item channel out of the geometry parser
interface gsp_rsp_if import gsp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       ok;
   logic signed [OUT_BITS-1:0] width;
   logic signed [OUT_BITS-1:0] height;
   logic signed [OUT_BITS-1:0] x_pos;
   logic signed [OUT_BITS-1:0] y_pos;
   logic                       has_size;
   logic                       has_position;

   modport source (output valid, output ok, output width, output height, output x_pos,
                   output y_pos, output has_size, output has_position, input ready);
   modport sink   (input valid, input ok, input width, input height, input x_pos,
                   input y_pos, input has_size, input has_position, output ready);
endinterface

/* rtl/gsp_char_step.sv */
// next parse state for one character of the geometry string
module gsp_char_step import gsp_pkg::*; (
   input  parse_state_type    cur,
   input  logic [CH_BITS-1:0] ch,
   output parse_state_type    nxt
);

   logic                  digit;
   logic                  sign;
   logic [VALUE_BITS-1:0] acc_sel;
   logic [VALUE_BITS-1:0] acc_new;

   assign digit = is_digit(ch);
   assign sign  = is_sign(ch);

   // only one accumulator moves per character, so one shared times-ten unit
   always_comb begin
      unique case (cur.phase)
         PH_START, PH_SIZE_W:           acc_sel = cur.width_acc;
         PH_SIZE_H:                     acc_sel = cur.height_acc;
         PH_POS_X_FIRST, PH_POS_X:      acc_sel = cur.x_acc;
         PH_POS_Y_FIRST, PH_POS_Y:      acc_sel = cur.y_acc;
         default:                       acc_sel = cur.width_acc;
      endcase
   end

   assign acc_new = acc_digit(acc_sel, ch);

   always_comb begin
      nxt = cur;
      unique case (cur.phase)
         PH_START: begin
            if (sign) begin
               nxt.x_negative    = (ch == CH_MINUS);
               nxt.position_seen = 1'b1;
               nxt.phase         = PH_POS_X_FIRST;
            end else if (ch == CH_EQUAL) begin
               nxt.phase = PH_SIZE_W;
            end else if (digit) begin
               nxt.width_acc = acc_new;
               nxt.phase     = PH_SIZE_W;
            end else if (ch == CH_X) begin
               nxt.size_seen = 1'b1;
               nxt.phase     = PH_SIZE_H;
            end else begin
               nxt.failed = 1'b1;
            end
         end
         PH_SIZE_W: begin
            if (digit) begin
               nxt.width_acc = acc_new;
            end else if (ch == CH_X) begin
               nxt.size_seen = 1'b1;
               nxt.phase     = PH_SIZE_H;
            end else begin
               nxt.failed = 1'b1;
            end
         end
         PH_SIZE_H: begin
            if (digit) begin
               nxt.height_acc = acc_new;
            end else if (sign) begin
               nxt.x_negative    = (ch == CH_MINUS);
               nxt.position_seen = 1'b1;
               nxt.phase         = PH_POS_X_FIRST;
            end else begin
               nxt.failed = 1'b1;
            end
         end
         PH_POS_X_FIRST, PH_POS_X: begin
            if (digit) begin
               nxt.x_acc = acc_new;
               nxt.phase = PH_POS_X;
            end else if ((cur.phase == PH_POS_X) && sign) begin
               nxt.y_negative = (ch == CH_MINUS);
               nxt.phase      = PH_POS_Y_FIRST;
            end else begin
               nxt.failed = 1'b1;
            end
         end
         PH_POS_Y_FIRST, PH_POS_Y: begin
            if (digit) begin
               nxt.y_acc = acc_new;
               nxt.phase = PH_POS_Y;
            end else begin
               nxt.failed = 1'b1;
            end
         end
         default: begin
            nxt.failed = 1'b1;
         end
      endcase
   end

endmodule

/* rtl/geometry_string_parser.sv */
// geometry string parser: an accepted end item passes through the input register into the result
// register; throughput one item per cycle; the input register advances unless an end item
// meets a result register that is still full and not being taken
// a character updates the parse state in the cycle after its acceptance; the end item
// loads the result register and returns the parse state to the start of a string
// synchronous active-high reset empties both registers and clears the parse state
module geometry_string_parser import gsp_pkg::*; (
   input logic    clock,
   input logic    reset,
   gsp_req_if.sink   req_chan,
   gsp_rsp_if.source rsp_chan
);

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [CH_BITS-1:0] in_ch_ff, in_ch_in;
   logic               in_end_ff, in_end_in;

   // parse state
   parse_state_type state_ff, state_in;
   parse_state_type state_step;

   // result register
   logic                       out_valid_ff, out_valid_in;
   logic                       out_ok_ff, out_ok_in;
   logic signed [OUT_BITS-1:0] out_width_ff, out_width_in;
   logic signed [OUT_BITS-1:0] out_height_ff, out_height_in;
   logic signed [OUT_BITS-1:0] out_x_ff, out_x_in;
   logic signed [OUT_BITS-1:0] out_y_ff, out_y_in;
   logic                       out_has_size_ff, out_has_size_in;
   logic                       out_has_pos_ff, out_has_pos_in;

   logic                advance;
   logic                req_take;
   logic                parse_ok;
   logic [OUT_BITS-1:0] x_mag;
   logic [OUT_BITS-1:0] y_mag;
   logic                x_is_minus_one;
   logic                y_is_minus_one;

   // a character item always moves on; an end item needs room in the result register
   assign advance  = in_valid_ff && (!in_end_ff || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_ch_in  = in_ch_ff;
      in_end_in = in_end_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_ch_in    = req_chan.ch;
         in_end_in   = req_chan.end_of_string;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   gsp_char_step u_step (
      .cur (state_ff),
      .ch  (in_ch_ff),
      .nxt (state_step)
   );

   // characters after a failure leave the state alone until the end item
   always_comb begin
      state_in = state_ff;
      if (advance) begin
         if (in_end_ff) begin
            state_in = STATE_RESET;
         end else if (!state_ff.failed) begin
            state_in = state_step;
         end
      end
   end

   // result of the string that the end item closes
   assign parse_ok = !state_ff.failed &&
                     ((state_ff.phase == PH_SIZE_H) || (state_ff.phase == PH_POS_Y));

   assign x_mag = OUT_BITS'(state_ff.x_acc);
   assign y_mag = OUT_BITS'(state_ff.y_acc);

   // an offset of exactly minus one still parses but does not count as a position
   assign x_is_minus_one = state_ff.x_negative && (state_ff.x_acc == VALUE_BITS'(1));
   assign y_is_minus_one = state_ff.y_negative && (state_ff.y_acc == VALUE_BITS'(1));

   always_comb begin
      out_ok_in       = out_ok_ff;
      out_width_in    = out_width_ff;
      out_height_in   = out_height_ff;
      out_x_in        = out_x_ff;
      out_y_in        = out_y_ff;
      out_has_size_in = out_has_size_ff;
      out_has_pos_in  = out_has_pos_ff;
      if (advance && in_end_ff) begin
         out_valid_in    = 1'b1;
         out_ok_in       = parse_ok;
         out_width_in    = '1;
         out_height_in   = '1;
         out_x_in        = '1;
         out_y_in        = '1;
         out_has_size_in = parse_ok && state_ff.size_seen;
         out_has_pos_in  = parse_ok && state_ff.position_seen &&
                           !x_is_minus_one && !y_is_minus_one;
         if (parse_ok && state_ff.size_seen) begin
            out_width_in  = OUT_BITS'(state_ff.width_acc);
            out_height_in = OUT_BITS'(state_ff.height_acc);
         end
         if (parse_ok && state_ff.position_seen) begin
            out_x_in = state_ff.x_negative ? -x_mag : x_mag;
            out_y_in = state_ff.y_negative ? -y_mag : y_mag;
         end
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_ch_ff        <= in_ch_in;
      in_end_ff       <= in_end_in;
      out_ok_ff       <= out_ok_in;
      out_width_ff    <= out_width_in;
      out_height_ff   <= out_height_in;
      out_x_ff        <= out_x_in;
      out_y_ff        <= out_y_in;
      out_has_size_ff <= out_has_size_in;
      out_has_pos_ff  <= out_has_pos_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.ok           = out_ok_ff;
   assign rsp_chan.width        = out_width_ff;
   assign rsp_chan.height       = out_height_ff;
   assign rsp_chan.x_pos        = out_x_ff;
   assign rsp_chan.y_pos        = out_y_ff;
   assign rsp_chan.has_size     = out_has_size_ff;
   assign rsp_chan.has_position = out_has_pos_ff;

endmodule

/* rtl/gsp_checker.sv */
// port-level checks on the geometry parser and the bind that attaches them
module gsp_checker import gsp_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_ok,
   input logic signed [OUT_BITS-1:0] rsp_width,
   input logic signed [OUT_BITS-1:0] rsp_height,
   input logic signed [OUT_BITS-1:0] rsp_x_pos,
   input logic signed [OUT_BITS-1:0] rsp_y_pos,
   input logic                       rsp_has_size,
   input logic                       rsp_has_position
);

   // a stalled result item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // a failed parse reports every value as minus one and no flags
   a_fail_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> (rsp_width == '1) && (rsp_height == '1) &&
                               (rsp_x_pos == '1) && (rsp_y_pos == '1) &&
                               !rsp_has_size && !rsp_has_position)
      else $error("failed parse with values set");

   // a size flag means a successful parse with a real size
   a_size_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_size |-> rsp_ok && (rsp_width != '1) && (rsp_height != '1))
      else $error("size flag without a size");

   // a position flag needs success and offsets other than minus one
   a_pos_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_position |-> rsp_ok && (rsp_x_pos != '1) && (rsp_y_pos != '1))
      else $error("position flag without a position");

endmodule

bind geometry_string_parser gsp_checker u_gsp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_ok           (rsp_chan.ok),
   .rsp_width        (rsp_chan.width),
   .rsp_height       (rsp_chan.height),
   .rsp_x_pos        (rsp_chan.x_pos),
   .rsp_y_pos        (rsp_chan.y_pos),
   .rsp_has_size     (rsp_chan.has_size),
   .rsp_has_position (rsp_chan.has_position)
);
